>>> rtl/hla_pkg.sv
// Shared types and constants for the free-list heap allocator.
// Header entry layout, shared arithmetic unit controls, heap geometry, codes.
// No dependencies.
package hla_pkg;

  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned LINK_W       = 17;
  localparam int unsigned CNT_W        = 17;
  localparam int unsigned ALU_W        = 18;

  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned INITIAL_BYTES = 4096;

  localparam logic [LINK_W-1:0] NIL_LINK = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // opcodes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_EXHAUST = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_DFREE   = 3'd4;

  // one header: payload size and next link (bit 16 = null)
  typedef struct packed {
    logic [ADDR_W-1:0] size;
    logic [LINK_W-1:0] link;
  } hdr_t;

  // shared add/subtract unit: res = a +/- b +/- header
  typedef struct packed {
    logic sub;
    logic hdr;
  } alu_ctl_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } alu_flags_t;

endpackage

>>> rtl/hla_hdr_mem.sv
// Header store: one size/link entry per byte offset of the heap.
// One write port, one read port with registered read data.
// Depends on hla_pkg.
module hla_hdr_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [hla_pkg::ADDR_W-1:0] waddr_i,
  input  hla_pkg::hdr_t             wdata_i,
  input  logic [hla_pkg::ADDR_W-1:0] raddr_i,
  output hla_pkg::hdr_t             rdata_o
);
  import hla_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  hdr_t mem_q [DEPTH];
  hdr_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hla_alu.sv
// Shared address/size arithmetic unit of the allocator sequencer.
// Adds or subtracts two operands and an optional header size, compares to c.
// Depends on hla_pkg.
module hla_alu (
  input  hla_pkg::alu_ctl_t          ctl_i,
  input  logic [hla_pkg::CNT_W-1:0]  a_i,
  input  logic [hla_pkg::CNT_W-1:0]  b_i,
  input  logic [hla_pkg::CNT_W-1:0]  c_i,
  output logic [hla_pkg::ALU_W-1:0]  res_o,
  output hla_pkg::alu_flags_t        flags_o
);
  import hla_pkg::*;

  localparam logic [ALU_W-1:0] HDR = ALU_W'(HEADER_BYTES);

  logic [ALU_W-1:0] a_x, b_x, h_x, c_x;

  always_comb begin
    a_x = {1'b0, a_i};
    b_x = {1'b0, b_i};
    c_x = {1'b0, c_i};
    h_x = ctl_i.hdr ? HDR : '0;
    if (ctl_i.sub) begin
      res_o = a_x - b_x - h_x;
    end else begin
      res_o = a_x + b_x + h_x;
    end
    flags_o.lt = res_o < c_x;
    flags_o.eq = res_o == c_x;
    flags_o.gt = res_o > c_x;
  end

endmodule

>>> rtl/free_list_heap_allocator_core.sv
// Channel     | dir | contents (low bit first)
// s_axis      | in  | opcode[1:0], request_size[17:2], payload_address[33:18]
// m_axis      | out | block_address[15:0], status[18:16], segment_bytes[35:19],
//             |     | free_bytes[52:36]
// cfg         | in  | fit_policy (cfg_wdata_i), written when cfg_we_i is high
//
// Init, zero-size, null-free and unused opcodes go straight from idle to output.
// Allocate: free-list nodes are read from the header memory one after another,
// then the headers are updated. Free: each node walked takes an address
// compare, then a link read, and is followed by linking and merging.
// These steps share the header memory read port and the shared adder.
// Reset needs no clearing pass; a finished result waits in the output
// register while the next beat is taken.
// Depends on hla_pkg, hla_hdr_mem, hla_alu.
module free_list_heap_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, request_size, payload_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // block_address, status, segment, free
);
  import hla_pkg::*;

  localparam logic [ADDR_W-1:0] HDR16  = ADDR_W'(HEADER_BYTES);
  localparam logic [ALU_W-1:0]  HDR18  = ALU_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  HEAP_C = CNT_W'(HEAP_BYTES);
  localparam logic [CNT_W-1:0]  INIT_C = CNT_W'(INITIAL_BYTES);
  localparam logic [ADDR_W-1:0] INIT_SZ = ADDR_W'(INITIAL_BYTES - HEADER_BYTES);
  localparam logic [2:0] PH_LAST = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_AWALK, S_AEND, S_FWALK, S_FWAIT, S_FSZ_RD, S_FSZ,
    S_SEQ, S_LW_WR, S_CO_B, S_CO_CHK, S_OUT
  } state_e;

  typedef enum logic [1:0] {K_SPLIT, K_UNLINK, K_FREE} kind_e;

  state_e state_q;
  kind_e  kind_q;

  logic [LINK_W-1:0] head_q, cur_q, prev_q, pick_q, pick_prev_q, pick_link_q, lw_val_q;
  logic [CNT_W-1:0]  brk_q, cnt_q, n_q, best_q;
  logic [ADDR_W-1:0] req_q, blk_q, pick_size_q, sz_q, nb_q, tgt_q, cob_q, ls_q;
  logic [2:0]        phase_q, res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  logic              policy_q, adj_q;
  logic              out_valid_q;
  logic [55:0]       out_data_q;

  // input fields
  logic [1:0]        in_op;
  logic [ADDR_W-1:0] in_req, in_pa;
  logic              in_fire;
  assign in_op   = s_axis_tdata[1:0];
  assign in_req  = s_axis_tdata[17:2];
  assign in_pa   = s_axis_tdata[33:18];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // memory and shared unit
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  hdr_t              mem_wdata, rd;
  alu_ctl_t          alu_ctl;
  logic [CNT_W-1:0]  alu_a, alu_b, alu_c;
  logic [ALU_W-1:0]  alu_res;
  alu_flags_t        alu_fl;

  hla_hdr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  hla_alu u_alu (
    .ctl_i   (alu_ctl),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .c_i     (alu_c),
    .res_o   (alu_res),
    .flags_o (alu_fl)
  );

  // walk decisions
  logic             aw_hit, aw_better, aw_stop;
  logic [CNT_W-1:0] n_inc;
  logic             fw_end, fw_dup, fw_adv;
  assign n_inc     = n_q + CNT_W'(1);
  assign aw_hit    = policy_q ? (rd.size == req_q) : (rd.size >= req_q);
  assign aw_better = policy_q && (rd.size > req_q) && ({1'b0, rd.size} < best_q);
  assign aw_stop   = rd.link[ADDR_W] || n_inc[ADDR_W];
  assign fw_end    = cur_q[ADDR_W] || n_q[ADDR_W];
  assign fw_dup    = !fw_end && (cur_q[ADDR_W-1:0] == blk_q);
  assign fw_adv    = !fw_end && (cur_q[ADDR_W-1:0] < blk_q);

  // counter updates
  logic [ALU_W-1:0] cnt_sum, sub_v;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  always_comb begin
    cnt_sum = {1'b0, cnt_q} + {2'b0, rd.size} + HDR18;
    cnt_inc = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
    sub_v   = alu_fl.lt ? alu_res : ({2'b0, pick_size_q} + HDR18);
    cnt_dec = (sub_v > {1'b0, cnt_q}) ? '0 : CNT_W'({1'b0, cnt_q} - sub_v);
  end

  // update sequence step decode
  logic              rmw_go, co_go, head_wr, seq_done;
  logic [ADDR_W-1:0] rmw_addr, co_lo, co_b;
  logic [LINK_W-1:0] rmw_val, head_val;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    alu_ctl   = '0;
    alu_a     = '0;
    alu_b     = '0;
    alu_c     = '0;
    rmw_go    = 1'b0;
    co_go     = 1'b0;
    head_wr   = 1'b0;
    seq_done  = 1'b0;
    rmw_addr  = '0;
    rmw_val   = '0;
    co_lo     = '0;
    co_b      = '0;
    head_val  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_op == OP_INIT) begin
          mem_we    = 1'b1;
          mem_wdata = '{size: INIT_SZ, link: NIL_LINK};
        end
        mem_raddr = head_q[ADDR_W-1:0];
      end
      S_AWALK: begin
        mem_raddr = rd.link[ADDR_W-1:0];
      end
      S_AEND: begin
        alu_ctl = '{sub: 1'b0, hdr: 1'b1};
        if (pick_q[ADDR_W]) begin
          alu_a = brk_q;
          alu_b = {1'b0, req_q};
          alu_c = HEAP_C;
          if (!alu_fl.gt) begin
            mem_we    = 1'b1;
            mem_waddr = brk_q[ADDR_W-1:0];
            mem_wdata = '{size: req_q, link: NIL_LINK};
          end
        end else begin
          alu_a = {1'b0, req_q};
          alu_c = {1'b0, pick_size_q};
        end
      end
      S_FWALK: begin
        mem_raddr = cur_q[ADDR_W-1:0];
      end
      S_FSZ_RD: begin
        mem_raddr = blk_q;
      end
      S_SEQ: begin
        unique case (kind_q)
          K_SPLIT: begin
            unique case (phase_q)
              3'd0: begin
                alu_ctl = '{sub: 1'b0, hdr: 1'b1};
                alu_a   = {1'b0, pick_q[ADDR_W-1:0]};
                alu_b   = {1'b0, req_q};
              end
              3'd1: begin
                alu_ctl   = '{sub: 1'b1, hdr: 1'b1};
                alu_a     = {1'b0, pick_size_q};
                alu_b     = {1'b0, req_q};
                mem_we    = 1'b1;
                mem_waddr = nb_q;
                mem_wdata = '{size: alu_res[ADDR_W-1:0], link: pick_link_q};
              end
              3'd2: begin
                mem_we    = 1'b1;
                mem_waddr = pick_q[ADDR_W-1:0];
                mem_wdata = '{size: req_q, link: NIL_LINK};
              end
              3'd3: begin
                if (pick_prev_q[ADDR_W]) begin
                  head_wr  = 1'b1;
                  head_val = {1'b0, nb_q};
                end else begin
                  rmw_go   = 1'b1;
                  rmw_addr = pick_prev_q[ADDR_W-1:0];
                  rmw_val  = {1'b0, nb_q};
                end
              end
              default: seq_done = 1'b1;
            endcase
          end
          K_UNLINK: begin
            unique case (phase_q)
              3'd0: begin
                if (pick_prev_q[ADDR_W]) begin
                  head_wr  = 1'b1;
                  head_val = pick_link_q;
                end else begin
                  rmw_go   = 1'b1;
                  rmw_addr = pick_prev_q[ADDR_W-1:0];
                  rmw_val  = pick_link_q;
                end
              end
              3'd1: begin
                mem_we    = 1'b1;
                mem_waddr = pick_q[ADDR_W-1:0];
                mem_wdata = '{size: pick_size_q, link: NIL_LINK};
              end
              default: seq_done = 1'b1;
            endcase
          end
          default: begin
            unique case (phase_q)
              3'd0: begin
                mem_we    = 1'b1;
                mem_waddr = blk_q;
                mem_wdata = '{size: sz_q, link: cur_q[ADDR_W] ? NIL_LINK : cur_q};
                if (prev_q[ADDR_W]) begin
                  head_wr  = 1'b1;
                  head_val = {1'b0, blk_q};
                end
              end
              3'd1: begin
                if (!prev_q[ADDR_W]) begin
                  rmw_go   = 1'b1;
                  rmw_addr = prev_q[ADDR_W-1:0];
                  rmw_val  = {1'b0, blk_q};
                end
              end
              3'd2: begin
                if (!cur_q[ADDR_W]) begin
                  co_go = 1'b1;
                  co_lo = blk_q;
                  co_b  = cur_q[ADDR_W-1:0];
                end
              end
              3'd3: begin
                if (!prev_q[ADDR_W]) begin
                  co_go = 1'b1;
                  co_lo = prev_q[ADDR_W-1:0];
                  co_b  = blk_q;
                end
              end
              default: seq_done = 1'b1;
            endcase
          end
        endcase
        if (rmw_go) begin
          mem_raddr = rmw_addr;
        end else if (co_go) begin
          mem_raddr = co_lo;
        end
      end
      S_LW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_q;
        mem_wdata = '{size: rd.size, link: lw_val_q};
      end
      S_CO_B: begin
        // does the lower block end exactly where the upper one starts
        alu_ctl   = '{sub: 1'b0, hdr: 1'b1};
        alu_a     = {1'b0, tgt_q};
        alu_b     = {1'b0, rd.size};
        alu_c     = {1'b0, cob_q};
        mem_raddr = cob_q;
      end
      S_CO_CHK: begin
        alu_ctl = '{sub: 1'b0, hdr: 1'b1};
        alu_a   = {1'b0, ls_q};
        alu_b   = {1'b0, rd.size};
        if (adj_q) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_q;
          mem_wdata = '{size: alu_res[ADDR_W-1:0], link: rd.link};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= K_FREE;
      head_q       <= NIL_LINK;
      brk_q        <= '0;
      cnt_q        <= '0;
      policy_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      phase_q      <= '0;
      cur_q        <= NIL_LINK;
      prev_q       <= NIL_LINK;
      pick_q       <= NIL_LINK;
      pick_prev_q  <= NIL_LINK;
      pick_link_q  <= NIL_LINK;
      lw_val_q     <= '0;
      n_q          <= '0;
      best_q       <= '0;
      req_q        <= '0;
      blk_q        <= '0;
      pick_size_q  <= '0;
      sz_q         <= '0;
      nb_q         <= '0;
      tgt_q        <= '0;
      cob_q        <= '0;
      ls_q         <= '0;
      adj_q        <= 1'b0;
      res_status_q <= ST_DONE;
      res_addr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      // S_OUT reloads the result register itself
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_status_q <= ST_DONE;
            res_addr_q   <= '0;
            req_q        <= in_req;
            blk_q        <= in_pa - HDR16;
            cur_q        <= head_q;
            prev_q       <= NIL_LINK;
            pick_q       <= NIL_LINK;
            pick_prev_q  <= NIL_LINK;
            best_q       <= NIL_LINK;
            n_q          <= '0;
            phase_q      <= '0;
            priority case (in_op)
              OP_INIT: begin
                head_q  <= '0;
                brk_q   <= INIT_C;
                cnt_q   <= INIT_C;
                state_q <= S_OUT;
              end
              OP_ALLOC: begin
                if (in_req == '0) begin
                  res_status_q <= ST_ZERO;
                  state_q      <= S_OUT;
                end else if (head_q[ADDR_W]) begin
                  state_q <= S_AEND;
                end else begin
                  state_q <= S_AWALK;
                end
              end
              OP_FREE: begin
                if (in_pa == '0) begin
                  res_status_q <= ST_NULL;
                  state_q      <= S_OUT;
                end else begin
                  state_q <= S_FWALK;
                end
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_AWALK: begin
          if (aw_hit || aw_better) begin
            pick_q      <= cur_q;
            pick_prev_q <= prev_q;
            pick_size_q <= rd.size;
            pick_link_q <= rd.link;
            best_q      <= {1'b0, rd.size};
          end
          if (aw_hit) begin
            state_q <= S_AEND;
          end else begin
            prev_q <= cur_q;
            cur_q  <= rd.link;
            n_q    <= n_inc;
            if (aw_stop) begin
              state_q <= S_AEND;
            end
          end
        end
        S_AEND: begin
          if (pick_q[ADDR_W]) begin
            if (alu_fl.gt) begin
              res_status_q <= ST_EXHAUST;
            end else begin
              res_addr_q <= brk_q[ADDR_W-1:0] + HDR16;
              brk_q      <= alu_res[CNT_W-1:0];
            end
            state_q <= S_OUT;
          end else begin
            kind_q     <= alu_fl.lt ? K_SPLIT : K_UNLINK;
            cnt_q      <= cnt_dec;
            res_addr_q <= pick_q[ADDR_W-1:0] + HDR16;
            state_q    <= S_SEQ;
          end
        end
        S_FWALK: begin
          if (fw_dup) begin
            res_status_q <= ST_DFREE;
            state_q      <= S_OUT;
          end else if (fw_adv) begin
            state_q <= S_FWAIT;
          end else begin
            state_q <= S_FSZ_RD;
          end
        end
        S_FWAIT: begin
          prev_q  <= cur_q;
          cur_q   <= rd.link;
          n_q     <= n_inc;
          state_q <= S_FWALK;
        end
        S_FSZ_RD: begin
          state_q <= S_FSZ;
        end
        S_FSZ: begin
          sz_q    <= rd.size;
          cnt_q   <= cnt_inc;
          kind_q  <= K_FREE;
          state_q <= S_SEQ;
        end
        S_SEQ: begin
          if (phase_q != PH_LAST) begin
            phase_q <= phase_q + 3'd1;
          end
          if (kind_q == K_SPLIT && phase_q == '0) begin
            nb_q <= alu_res[ADDR_W-1:0];
          end
          if (head_wr) begin
            head_q <= head_val;
          end
          if (rmw_go) begin
            tgt_q    <= rmw_addr;
            lw_val_q <= rmw_val;
            state_q  <= S_LW_WR;
          end else if (co_go) begin
            tgt_q   <= co_lo;
            cob_q   <= co_b;
            state_q <= S_CO_B;
          end else if (seq_done) begin
            state_q <= S_OUT;
          end
        end
        S_LW_WR: begin
          state_q <= S_SEQ;
        end
        S_CO_B: begin
          ls_q    <= rd.size;
          adj_q   <= alu_fl.eq;
          state_q <= S_CO_CHK;
        end
        S_CO_CHK: begin
          state_q <= S_SEQ;
        end
        default: begin
          // S_OUT: load the result register once it is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b0, cnt_q, brk_q, res_status_q, res_addr_q};
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_walk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AWALK) |-> !cur_q[ADDR_W])
    else $error("allocate walk on a null link");

  a_init_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_op == OP_INIT) |=> (head_q == '0 && brk_q == INIT_C))
    else $error("init did not set up the first free block");

  a_grow_brk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AEND && pick_q[ADDR_W] && !alu_fl.gt) |=> (brk_q > $past(brk_q)))
    else $error("break did not advance on heap growth");

  a_rmw_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LW_WR || state_q == S_CO_B) |-> ($past(state_q) == S_SEQ))
    else $error("link update entered outside the update sequence");
`endif

endmodule
